@@ hdl/bounded_set_table_unit_macros.svh @@
// Assertion macros shared by the bounded set table RTL.
// Included by the top level; depends on nothing else.
`ifndef BOUNDED_SET_TABLE_UNIT_MACROS_SVH
`define BOUNDED_SET_TABLE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BST_ASSERT_SAME(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BST_ASSERT_NEXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/bst_pkg.sv @@
// Package for the bounded set table: command codes, payload types and defaults.
// Used by the interfaces, the sequencer and the top level.
`default_nettype none

package bst_pkg;

    localparam int DEF_CAPACITY    = 16;
    localparam int DEF_ENTRY_WIDTH = 32;

    localparam int CMD_W   = 2;
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 4;
    localparam int FILL_W  = 5;

    typedef logic [CMD_W-1:0]   cmd_t;
    typedef logic [VALUE_W-1:0] value_t;

    localparam cmd_t CMD_ADD    = 2'd0;
    localparam cmd_t CMD_REMOVE = 2'd1;
    localparam cmd_t CMD_LOOKUP = 2'd2;
    localparam cmd_t CMD_CLEAR  = 2'd3;

    // Result of one command as handed from the sequencer to the output stage.
    typedef struct packed {
        logic               ok;
        logic               found;
        logic [INDEX_W-1:0] match_slot;
        logic [FILL_W-1:0]  fill_count;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/bst_cmd_if.sv @@
// Command channel of the bounded set table: valid/ready plus command and value.
// Depends on bst_pkg.
`default_nettype none

interface bst_cmd_if;
    import bst_pkg::*;

    logic   valid;
    logic   ready;
    cmd_t   command;
    value_t value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

`default_nettype wire

@@ hdl/bst_res_if.sv @@
// Result channel of the bounded set table: valid/ready plus the result fields.
// Depends on bst_pkg.
`default_nettype none

interface bst_res_if;
    import bst_pkg::*;

    logic               valid;
    logic               ready;
    logic               ok;
    logic               found;
    logic [INDEX_W-1:0] match_slot;
    logic [FILL_W-1:0]  fill_count;

    modport source (output valid, output ok, output found, output match_slot,
                    output fill_count, input ready);
    modport sink   (input valid, input ok, input found, input match_slot,
                    input fill_count, output ready);
endinterface

`default_nettype wire

@@ hdl/bst_store.sv @@
// Entry store of the bounded set table: one write port, one registered read port.
// Standalone; no package contents needed.
`default_nettype none

module bst_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hdl/bst_ctrl.sv @@
// Sequencer of the bounded set table: scans the store with one shared comparator,
// then appends, moves, clears or only reports. Depends on bst_pkg and drives bst_store.
`default_nettype none

module bst_ctrl #(
    parameter int CAPACITY    = bst_pkg::DEF_CAPACITY,
    parameter int ENTRY_WIDTH = bst_pkg::DEF_ENTRY_WIDTH,
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cmd_valid,
    output logic                        cmd_ready,
    input  wire bst_pkg::cmd_t          cmd_command,
    input  wire bst_pkg::value_t        cmd_value,
    output logic                        mem_we,
    output logic      [IW-1:0]          mem_waddr,
    output logic      [ENTRY_WIDTH-1:0] mem_wdata,
    output logic      [IW-1:0]          mem_raddr,
    input  wire logic [ENTRY_WIDTH-1:0] mem_rdata,
    output logic                        done_valid,
    input  wire logic                   done_take,
    output bst_pkg::result_t            done_result
);
    import bst_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_ACT  = 3'd2;
    localparam logic [2:0] S_MOVE = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]             state_reg,   state_next;
    cmd_t                   cmd_reg,     cmd_next;
    logic [ENTRY_WIDTH-1:0] value_reg,   value_next;
    logic [CW-1:0]          count_reg,   count_next;
    logic [IW-1:0]          addr_reg,    addr_next;
    logic [IW-1:0]          cmp_idx_reg, cmp_idx_next;
    logic                   pend_reg,    pend_next;
    logic                   hit_reg,     hit_next;
    logic [IW-1:0]          hit_idx_reg, hit_idx_next;
    logic                   ok_reg,      ok_next;

    logic [CW-1:0]                  count_m1;
    logic [IW-1:0]                  last_idx;
    logic [ENTRY_WIDTH+VALUE_W-1:0] value_wide;
    logic                           match;
    logic                           at_last;
    logic                           room;
    logic [IW+INDEX_W-1:0]          idx_wide;
    logic [CW+FILL_W-1:0]           count_wide;

    assign count_m1   = count_reg - CW'(1);
    assign last_idx   = count_m1[IW-1:0];
    assign value_wide = {{ENTRY_WIDTH{1'b0}}, cmd_value};
    // The shared comparator: the entry read in the previous cycle against the key.
    assign match      = pend_reg && (mem_rdata == value_reg);
    assign at_last    = pend_reg && (CW'(cmp_idx_reg) == count_m1);
    assign room       = count_reg < CW'(CAPACITY);
    assign idx_wide   = {{INDEX_W{1'b0}}, hit_idx_reg};
    assign count_wide = {{FILL_W{1'b0}}, count_reg};

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        value_next   = value_reg;
        count_next   = count_reg;
        addr_next    = addr_reg;
        cmp_idx_next = cmp_idx_reg;
        pend_next    = pend_reg;
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        ok_next      = ok_reg;
        mem_we       = 1'b0;
        mem_waddr    = count_reg[IW-1:0];
        mem_wdata    = value_reg;
        mem_raddr    = addr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next     = cmd_command;
                    value_next   = value_wide[ENTRY_WIDTH-1:0];
                    addr_next    = '0;
                    pend_next    = 1'b0;
                    hit_next     = 1'b0;
                    hit_idx_next = '0;
                    state_next   = (count_reg == '0) ? S_ACT : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (match)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    pend_next    = 1'b0;
                    state_next   = S_ACT;
                end
                else if (at_last)
                begin
                    pend_next  = 1'b0;
                    state_next = S_ACT;
                end
                else
                begin
                    pend_next    = 1'b1;
                    cmp_idx_next = addr_reg;
                    addr_next    = addr_reg + IW'(1);
                end
            end
            S_ACT:
            begin
                state_next = S_DONE;
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        ok_next = room;
                        if (room && !hit_reg)
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    CMD_REMOVE:
                    begin
                        ok_next = hit_reg;
                        if (hit_reg)
                        begin
                            mem_raddr  = last_idx;
                            state_next = S_MOVE;
                        end
                    end
                    CMD_LOOKUP:
                    begin
                        ok_next = hit_reg;
                    end
                    default:
                    begin
                        ok_next    = 1'b1;
                        count_next = '0;
                    end
                endcase
            end
            S_MOVE:
            begin
                // The last entry fills the hole left by the removed one.
                mem_we     = 1'b1;
                mem_waddr  = hit_idx_reg;
                mem_wdata  = mem_rdata;
                count_next = count_m1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (done_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        value_reg   <= value_next;
        addr_reg    <= addr_next;
        cmp_idx_reg <= cmp_idx_next;
        hit_reg     <= hit_next;
        hit_idx_reg <= hit_idx_next;
        ok_reg      <= ok_next;
    end

    assign cmd_ready              = (state_reg == S_IDLE);
    assign done_valid             = (state_reg == S_DONE);
    assign done_result.ok         = ok_reg;
    assign done_result.found      = hit_reg;
    assign done_result.match_slot = idx_wide[INDEX_W-1:0];
    assign done_result.fill_count = count_wide[FILL_W-1:0];

endmodule

`default_nettype wire

@@ hdl/bounded_set_table_unit.sv @@
// Bounded set table: the time from accepting an item to its result is set by the store
// scan over up to the N filled slots, N being the fill count, one entry compare per cycle
// through one read port; a remove that hits adds a move step. One item is worked on
// at a time; a new item is taken once the sequencer is back in idle after the last
// result moves to the output register. Reset empties the set (fill count zero) at once.
`default_nettype none

`include "bounded_set_table_unit_macros.svh"

module bounded_set_table_unit #(
    parameter int CAPACITY    = bst_pkg::DEF_CAPACITY,
    parameter int ENTRY_WIDTH = bst_pkg::DEF_ENTRY_WIDTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bst_cmd_if.sink   cmd,
    bst_res_if.source res
);
    import bst_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Store access from the sequencer. An entry not yet written never takes part in a
    // compare, because the scan only compares slots below the fill count.
    logic                   mem_we;
    logic [IW-1:0]          mem_waddr;
    logic [ENTRY_WIDTH-1:0] mem_wdata;
    logic [IW-1:0]          mem_raddr;
    logic [ENTRY_WIDTH-1:0] mem_rdata;

    // Finished result handed to the output register.
    logic    done_valid;
    logic    done_take;
    result_t done_result;

    logic    out_valid_reg;
    result_t out_res_reg;

    bst_store #(
        .DEPTH (CAPACITY),
        .WIDTH (ENTRY_WIDTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bst_ctrl #(
        .CAPACITY    (CAPACITY),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd.valid),
        .cmd_ready   (cmd.ready),
        .cmd_command (cmd.command),
        .cmd_value   (cmd.value),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .done_valid  (done_valid),
        .done_take   (done_take),
        .done_result (done_result)
    );

    // The output register takes a finished result whenever it is empty or its
    // current item is being taken in the same cycle, so the sequencer can return
    // to idle while the consumer stalls.
    assign done_take = done_valid && (!out_valid_reg || res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_take)
        begin
            out_res_reg <= done_result;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.ok         = out_res_reg.ok;
    assign res.found      = out_res_reg.found;
    assign res.match_slot = out_res_reg.match_slot;
    assign res.fill_count = out_res_reg.fill_count;

    // An accepted item keeps the sequencer busy for at least the next cycle.
    `BST_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, cmd.valid && cmd.ready, !cmd.ready,
                     "command accepted twice in a row")
    // A miss always reports slot zero.
    `BST_ASSERT_SAME(a_miss_index_zero, clk, rst_n, res.valid && !res.found,
                     res.match_slot == '0, "miss with nonzero index")
    // A result handed over shows up on the result channel in the next cycle.
    `BST_ASSERT_NEXT(a_take_shows_result, clk, rst_n, done_take, res.valid,
                     "taken result not presented")

endmodule

`default_nettype wire
